// File: design/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants for the CIGAR position projection block.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int POS_WIDTH_DEF   = 32;
  localparam int LEN_WIDTH_DEF   = 28;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int POS_FIELD_W    = 32;
  localparam int LMM_FIELD_W    = 32;
  localparam int OP_CODE_W      = 4;
  localparam int OP_LEN_W       = 28;
  localparam int IN_TDATA_W     = 96;
  localparam int MAPPED_W       = 32;
  localparam int OUT_TDATA_W    = 32;
  localparam int CFG_ADDR_W     = 1;
  localparam int CFG_DATA_W     = 1;

  localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SNAP_LEFT = 1'd1;

  typedef enum logic [OP_CODE_W-1:0] {
    OP_M  = 4'd0,
    OP_I  = 4'd1,
    OP_D  = 4'd2,
    OP_N  = 4'd3,
    OP_S  = 4'd4,
    OP_H  = 4'd5,
    OP_P  = 4'd6,
    OP_EQ = 4'd7,
    OP_X  = 4'd8
  } op_code_t;

  // Walk action that one operation asks of the back end.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_QC_ADD,
    ACT_RP_ADD,
    ACT_BOTH_ADD,
    ACT_INS_SNAP,
    ACT_GAP_SNAP
  } act_t;

  typedef struct packed {
    logic first;
    logic last;
    logic dir;
    logic snap_left;
    logic init_done;
    act_t act;
  } ctrl_t;

endpackage

// File: design/cpp_front.sv
// ----------------------------------------------------------------------------
// cpp_front
// Holds the configuration, classifies each operation into a walk action and
// computes the starting state at the first operation of an alignment.
// ----------------------------------------------------------------------------
module cpp_front #(
  parameter int POS_WIDTH = cpp_pkg::POS_WIDTH_DEF,
  parameter int LEN_WIDTH = cpp_pkg::LEN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cpp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cpp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_tvalid,
  input  logic [cpp_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                          in_tlast,
  input  logic                          q_full,
  output logic                          in_tready,
  output logic                          q_push,
  output cpp_pkg::ctrl_t                q_ctrl,
  output logic [POS_WIDTH-1:0]          q_len,
  output logic [POS_WIDTH-1:0]          q_pos,
  output logic [POS_WIDTH-1:0]          q_init_rp
);
  import cpp_pkg::*;

  localparam int LenKeep = (LEN_WIDTH < OP_LEN_W) ? LEN_WIDTH : OP_LEN_W;

  logic                  direction_r;
  logic                  snap_left_r;
  logic                  first_r;
  logic signed [POS_FIELD_W-1:0] pos_f;
  logic signed [LMM_FIELD_W-1:0] lmm_f;
  logic [OP_CODE_W-1:0]  code_f;
  logic [OP_LEN_W-1:0]   len_f;
  logic [LenKeep-1:0]    len_keep;
  logic [POS_WIDTH-1:0]  pos_w;
  logic [POS_WIDTH-1:0]  lmm_w;
  logic [POS_WIDTH-1:0]  init_sel;
  act_t                  act;

  assign pos_f    = in_tdata[POS_FIELD_W-1:0];
  assign lmm_f    = in_tdata[POS_FIELD_W+LMM_FIELD_W-1:POS_FIELD_W];
  assign code_f   = in_tdata[POS_FIELD_W+LMM_FIELD_W+OP_CODE_W-1:POS_FIELD_W+LMM_FIELD_W];
  assign len_f    = in_tdata[IN_TDATA_W-1:POS_FIELD_W+LMM_FIELD_W+OP_CODE_W];
  assign len_keep = len_f[LenKeep-1:0];

  assign pos_w = POS_WIDTH'(pos_f);
  assign lmm_w = POS_WIDTH'(lmm_f);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    act = ACT_NONE;
    case (op_code_t'(code_f))
      OP_M, OP_EQ, OP_X: begin
        act = ACT_QC_ADD;
      end
      OP_S: begin
        act = direction_r ? ACT_BOTH_ADD : ACT_QC_ADD;
      end
      OP_I: begin
        act = direction_r ? ACT_BOTH_ADD : ACT_INS_SNAP;
      end
      OP_D, OP_N: begin
        act = direction_r ? ACT_GAP_SNAP : ACT_RP_ADD;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  always_comb begin
    if (direction_r) begin
      q_init_rp = pos_w - lmm_w + POS_WIDTH'(1);
    end else begin
      q_init_rp = pos_w + lmm_w - POS_WIDTH'(1);
    end
    init_sel = direction_r ? q_init_rp : pos_w;
  end

  assign q_len               = POS_WIDTH'(len_keep);
  assign q_pos               = pos_w;
  assign q_ctrl.first        = first_r;
  assign q_ctrl.last         = in_tlast;
  assign q_ctrl.dir          = direction_r;
  assign q_ctrl.snap_left    = snap_left_r;
  assign q_ctrl.init_done    = init_sel[POS_WIDTH-1] || (init_sel == '0);
  assign q_ctrl.act          = act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      snap_left_r <= 1'b0;
      first_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DIRECTION: direction_r <= cfg_wdata[0];
          REG_SNAP_LEFT: snap_left_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (q_push) begin
        first_r <= in_tlast;
      end
    end
  end

endmodule

// File: design/cpp_queue.sv
// ----------------------------------------------------------------------------
// cpp_queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cpp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  count_r;

  assign full      = (count_r == CntW'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntW'(1);
      end
    end
  end

endmodule

// File: design/cpp_back.sv
// ----------------------------------------------------------------------------
// cpp_back
// Walks the alignment one operation per cycle, pausing on an empty queue or
// on a last operation whose result the output register cannot yet take.
// ----------------------------------------------------------------------------
module cpp_back #(
  parameter int POS_WIDTH = cpp_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  cpp_pkg::ctrl_t                  q_ctrl,
  input  logic [POS_WIDTH-1:0]            q_len,
  input  logic [POS_WIDTH-1:0]            q_pos,
  input  logic [POS_WIDTH-1:0]            q_init_rp,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cpp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import cpp_pkg::*;

  logic [POS_WIDTH-1:0] rp_r, qc_r, tq_r;
  logic                 wd_r;
  logic [POS_WIDTH-1:0] rp_e, qc_e, tq_e;
  logic                 wd_e;
  logic [POS_WIDTH-1:0] rp_nxt, qc_nxt, w_ins, w_gap, cmp_rhs;
  logic                 wd_nxt;
  logic                 na;
  logic                 out_free;
  logic                 out_valid_r;
  logic [MAPPED_W-1:0]  out_pos_r;
  logic                 out_na_r;
  logic                 expect_first_r;

  assign out_free = !out_valid_r || out_tready;
  assign q_pop    = !q_empty && (!q_ctrl.last || out_free);

  always_comb begin
    if (q_ctrl.first) begin
      rp_e = q_init_rp;
      qc_e = '0;
      tq_e = q_pos;
      wd_e = q_ctrl.init_done;
    end else begin
      rp_e = rp_r;
      qc_e = qc_r;
      tq_e = tq_r;
      wd_e = wd_r;
    end
  end

  assign w_ins = tq_e - qc_e;
  assign w_gap = rp_e - qc_e;

  always_comb begin
    rp_nxt = rp_e;
    qc_nxt = qc_e;
    if (!wd_e) begin
      case (q_ctrl.act)
        ACT_QC_ADD: begin
          qc_nxt = qc_e + q_len;
        end
        ACT_RP_ADD: begin
          rp_nxt = rp_e + q_len;
        end
        ACT_BOTH_ADD: begin
          rp_nxt = rp_e + q_len;
          qc_nxt = qc_e + q_len;
        end
        ACT_INS_SNAP: begin
          if ($signed(q_len) < $signed(w_ins)) begin
            rp_nxt = rp_e - q_len;
          end else begin
            rp_nxt = rp_e - w_ins + POS_WIDTH'(!q_ctrl.snap_left);
          end
          qc_nxt = qc_e + q_len;
        end
        ACT_GAP_SNAP: begin
          if ($signed(q_len) < $signed(w_gap)) begin
            rp_nxt = rp_e - q_len;
          end else begin
            rp_nxt = qc_e + POS_WIDTH'(!q_ctrl.snap_left);
          end
        end
        default: begin
        end
      endcase
    end
    cmp_rhs = q_ctrl.dir ? rp_nxt : tq_e;
    wd_nxt  = wd_e || !($signed(qc_nxt) < $signed(cmp_rhs));
  end

  always_comb begin
    if (q_ctrl.dir) begin
      na = rp_nxt[POS_WIDTH-1] || (rp_nxt == '0) || !wd_nxt;
    end else begin
      na = tq_e[POS_WIDTH-1] || (tq_e == '0) || !wd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r           <= '0;
      qc_r           <= '0;
      tq_r           <= '0;
      wd_r           <= 1'b0;
      out_valid_r    <= 1'b0;
      expect_first_r <= 1'b1;
    end else begin
      if (q_pop) begin
        rp_r           <= rp_nxt;
        qc_r           <= qc_nxt;
        tq_r           <= tq_e;
        wd_r           <= wd_nxt;
        expect_first_r <= q_ctrl.last;
      end
      if (q_pop && q_ctrl.last) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_ctrl.last) begin
      out_pos_r <= na ? '0 : MAPPED_W'(rp_nxt);
      out_na_r  <= na;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pos_r;
  assign out_tuser  = out_na_r;

  a_na_zero_pos : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_na_r |-> out_pos_r == '0)
    else $error("NA result carries a nonzero position");

  a_first_in_order : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_ctrl.first == expect_first_r)
    else $error("First-operation mark out of step with alignment boundaries");

  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_ctrl.last |-> out_free)
    else $error("Result register overwritten before it was taken");

  a_result_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(q_pop && q_ctrl.last))
    else $error("Result word raised without a last operation");

endmodule

// File: design/cigar_position_projection.sv
// ----------------------------------------------------------------------------
// cigar_position_projection
// Projects one position through an alignment's parsed CIGAR operations,
// query to reference or reference to query.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// in_       in   tvalid / tready    tdata: position, leftmost_pos, op_code,
//                                   op_len; tlast: last_op
// out_      out  tvalid / tready    tdata: mapped_pos; tuser: is_na
// cfg_      in   we                 addr: register index; wdata: value
//
// One operation is taken per cycle while the queue is not full; the walk
// step in the back end (one add, subtract and compare) sets that figure. A
// result word is registered in the back end once its last operation leaves
// the queue. The queue lets the input keep flowing while a result waits on
// out_tready. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module cigar_position_projection #(
  parameter int POS_WIDTH   = cpp_pkg::POS_WIDTH_DEF,
  parameter int LEN_WIDTH   = cpp_pkg::LEN_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cpp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cpp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // position, leftmost_pos, op_code, op_len
  input  logic [cpp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mapped_pos
  output logic [cpp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // is_na
  output logic                            out_tuser
);
  import cpp_pkg::*;

  localparam int EntryW = $bits(ctrl_t) + 3 * POS_WIDTH;

  logic                 q_push, q_pop, q_full, q_empty;
  ctrl_t                f_ctrl, b_ctrl;
  logic [POS_WIDTH-1:0] f_len, f_pos, f_init_rp;
  logic [POS_WIDTH-1:0] b_len, b_pos, b_init_rp;
  logic [EntryW-1:0]    q_din, q_dout;

  cpp_front #(
    .POS_WIDTH (POS_WIDTH),
    .LEN_WIDTH (LEN_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .in_tready (in_tready),
    .q_push    (q_push),
    .q_ctrl    (f_ctrl),
    .q_len     (f_len),
    .q_pos     (f_pos),
    .q_init_rp (f_init_rp)
  );

  assign q_din = {f_ctrl, f_len, f_pos, f_init_rp};
  assign {b_ctrl, b_len, b_pos, b_init_rp} = q_dout;

  cpp_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_din),
    .pop       (q_pop),
    .head_data (q_dout),
    .full      (q_full),
    .empty     (q_empty)
  );

  cpp_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctrl     (b_ctrl),
    .q_len      (b_len),
    .q_pos      (b_pos),
    .q_init_rp  (b_init_rp),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks cigar_position_projection against a predictor written here. The
// predictor walks each alignment's operations as they are accepted and
// queues the projected position; every result word is compared field by
// field with the oldest queued one. Directed alignments cover both
// directions, both snap sides, wrap-around, huge lengths, ignored codes and
// a direction change inside one alignment. Random alignments with bursty
// input and a stalling output follow, plus one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import cpp_pkg::*;

  localparam int RESULT_LATENCY = 4;
  localparam logic [OP_CODE_W-1:0] OP_UNUSED = 4'd15;
  localparam logic [OP_CODE_W-1:0] OP_SPARE_LO = 4'd9;

  typedef struct packed {
    logic [OP_LEN_W-1:0]     len;
    logic [OP_CODE_W-1:0]    code;
    logic [LMM_FIELD_W-1:0]  lmm;
    logic [POS_FIELD_W-1:0]  pos;
  } cigar_word_t;

  typedef struct {
    logic [MAPPED_W-1:0] mapped;
    logic                na;
  } projection_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  logic        dir_q, narrow_q;
  logic [31:0] walk_pos, query_used, query_goal;
  logic        aln_open, walk_finished;
  projection_t pending_projections[$];

  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;

  cigar_position_projection u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic logic s_less(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic void walk_query_to_ref(input logic [3:0] code, input logic [31:0] len);
    logic [31:0] gap;
    gap = query_goal - query_used;
    case (code)
      OP_M, OP_EQ, OP_X, OP_S: query_used = query_used + len;
      OP_I: begin
        if (s_less(len, gap)) walk_pos = walk_pos - len;
        else walk_pos = walk_pos - gap + (narrow_q ? 32'd0 : 32'd1);
        query_used = query_used + len;
      end
      OP_D, OP_N: walk_pos = walk_pos + len;
      default: ;
    endcase
  endfunction

  function automatic void walk_ref_to_query(input logic [3:0] code, input logic [31:0] len);
    logic [31:0] gap;
    gap = walk_pos - query_used;
    case (code)
      OP_M, OP_EQ, OP_X: query_used = query_used + len;
      OP_I, OP_S: begin
        walk_pos = walk_pos + len;
        query_used = query_used + len;
      end
      OP_D, OP_N: begin
        if (s_less(len, gap)) walk_pos = walk_pos - len;
        else if (narrow_q) walk_pos = query_used;
        else walk_pos = query_used + 32'd1;
      end
      default: ;
    endcase
  endfunction

  // Advances the alignment walk by one operation; returns 1 when a result
  // word is due, which happens on the last operation only.
  function automatic logic project_op(input cigar_word_t w, input logic last,
                                      output projection_t r);
    logic [31:0] len;
    len = 32'(w.len);
    if (!aln_open) begin
      query_goal = w.pos;
      query_used = '0;
      walk_pos = dir_q ? w.pos - w.lmm + 32'd1 : w.pos + w.lmm - 32'd1;
      walk_finished = !s_less(32'd0, dir_q ? walk_pos : query_goal);
      aln_open = 1'b1;
    end
    if (!walk_finished) begin
      if (dir_q) walk_ref_to_query(w.code, len);
      else walk_query_to_ref(w.code, len);
      walk_finished = !s_less(query_used, dir_q ? walk_pos : query_goal);
    end
    r.na = !s_less(32'd0, dir_q ? walk_pos : query_goal) || !walk_finished;
    r.mapped = r.na ? '0 : walk_pos;
    if (last) aln_open = 1'b0;
    return last;
  endfunction

  always @(posedge clk) begin
    projection_t want, got;
    logic emit;
    if (!rst_n) begin
      dir_q = 1'b0;
      narrow_q = 1'b0;
      walk_pos = '0;
      query_used = '0;
      query_goal = '0;
      aln_open = 1'b0;
      walk_finished = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DIRECTION: dir_q = cfg_wdata[0];
          REG_SNAP_LEFT: narrow_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (pending_projections.size() == 0) begin
          error_count++;
          $error("unexpected result word: mapped_pos %0d is_na %0b",
                 $signed(out_tdata), out_tuser);
        end else begin
          want = pending_projections.pop_front();
          if (out_tdata !== want.mapped) begin
            error_count++;
            $error("mapped_pos: expected %0d, got %0d",
                   $signed(want.mapped), $signed(out_tdata));
          end
          if (out_tuser !== want.na) begin
            error_count++;
            $error("is_na: expected %0b, got %0b", want.na, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        emit = project_op(cigar_word_t'(in_tdata), in_tlast, got);
        if (emit) pending_projections.push_back(got);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= !out_tready;
      endcase
    end
  end

  task automatic send_op(input logic [31:0] pos, input logic [31:0] lmm,
                         input logic [3:0] code, input logic [27:0] len,
                         input logic last);
    cigar_word_t w;
    w.pos = pos;
    w.lmm = lmm;
    w.code = code;
    w.len = len;
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_projections.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic configure(input logic dir, input logic narrow);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DIRECTION;
    cfg_wdata <= dir;
    @(posedge clk);
    cfg_addr <= REG_SNAP_LEFT;
    cfg_wdata <= narrow;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_query_to_ref();
    configure(1'b0, 1'b0);
    send_op(32'd5, 32'd100, OP_M, 28'd10, 1'b1);
    send_op(32'd7, 32'd100, OP_M, 28'd5, 1'b0);
    send_op(32'd0, 32'd0, OP_I, 28'd4, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd5, 1'b1);
    send_op(32'd0, 32'd1, OP_M, 28'd10, 1'b1);
    send_op(32'h8000_0000, 32'h7FFF_FFFF, OP_M, 28'hFFF_FFFF, 1'b1);
    send_op(32'd3, 32'd10, OP_UNUSED, 28'd0, 1'b1);
    send_op(32'd50, 32'd1, OP_M, 28'd10, 1'b1);
    send_op(32'd4, 32'h7FFF_FFFF, OP_S, 28'd2, 1'b0);
    send_op(32'hFFFF_FFFF, 32'h8000_0000, OP_H, 28'd5, 1'b0);
    send_op(32'd0, 32'd0, OP_P, 28'd1, 1'b0);
    send_op(32'd0, 32'd0, OP_SPARE_LO, 28'd7, 1'b0);
    send_op(32'd0, 32'd0, OP_D, 28'd3, 1'b0);
    send_op(32'd0, 32'd0, OP_N, 28'd2, 1'b0);
    send_op(32'd0, 32'd0, OP_EQ, 28'd1, 1'b0);
    send_op(32'd0, 32'd0, OP_X, 28'd1, 1'b1);
    wait_idle();
    configure(1'b0, 1'b1);
    send_op(32'd7, 32'd100, OP_M, 28'd5, 1'b0);
    send_op(32'd0, 32'd0, OP_I, 28'd4, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd5, 1'b1);
    wait_idle();
  endtask

  task automatic test_ref_to_query();
    configure(1'b1, 1'b1);
    send_op(32'd110, 32'd100, OP_M, 28'd5, 1'b0);
    send_op(32'd0, 32'd0, OP_D, 28'd10, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd5, 1'b1);
    send_op(32'd100, 32'd100, OP_S, 28'd3, 1'b0);
    send_op(32'd0, 32'd0, OP_I, 28'd2, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd4, 1'b1);
    wait_idle();
    configure(1'b1, 1'b0);
    send_op(32'd110, 32'd100, OP_M, 28'd5, 1'b0);
    send_op(32'd0, 32'd0, OP_N, 28'd10, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd5, 1'b1);
    send_op(32'd50, 32'd100, OP_M, 28'd10, 1'b1);
    wait_idle();
  endtask

  task automatic test_direction_switch();
    configure(1'b0, 1'b0);
    send_op(32'd5, 32'd100, OP_M, 28'd2, 1'b0);
    wait_idle();
    configure(1'b1, 1'b0);
    send_op(32'd0, 32'd0, OP_M, 28'd10, 1'b1);
    wait_idle();
  endtask

  task automatic send_random_alignment(input logic dir);
    logic [31:0] pos, lmm;
    logic [3:0]  code;
    logic [27:0] len;
    int          n_ops;
    lmm = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(1, 2000);
    if (dir) pos = lmm + $urandom_range(0, 80) - 8;
    else pos = $urandom_range(0, 80) - 4;
    if ($urandom_range(0, 7) == 0) pos = $urandom();
    n_ops = $urandom_range(1, 8);
    for (int k = 0; k < n_ops; k++) begin
      if ($urandom_range(0, 2) == 0) code = OP_M;
      else if ($urandom_range(0, 9) == 0) code = 4'($urandom_range(OP_SPARE_LO, OP_UNUSED));
      else code = 4'($urandom_range(OP_M, OP_X));
      len = ($urandom_range(0, 15) == 0) ? 28'($urandom()) : 28'($urandom_range(0, 24));
      send_op(k == 0 ? pos : $urandom(), k == 0 ? lmm : $urandom(), code, len,
              k == n_ops - 1);
    end
  endtask

  task automatic test_random_alignments();
    int unsigned stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      configure(phase[1], phase[0]);
      stop_at = words_sent + 390;
      while (words_sent < stop_at) send_random_alignment(phase[1]);
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    configure(1'b0, 1'b1);
    hold_request = 300;
    for (int k = 0; k < 40; k++) begin
      send_op($urandom_range(1, 30), $urandom_range(1, 1000), OP_M,
              28'($urandom_range(0, 40)), 1'b1);
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_query_to_ref();
    test_ref_to_query();
    test_direction_switch();
    test_random_alignments();
    test_output_backpressure();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
